### rtl/bounded_ordered_list_engine_core_defines.svh
`ifndef BOUNDED_ORDERED_LIST_ENGINE_CORE_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_CORE_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define BOLE_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("bole: invariant violated");

// Antecedent at an edge implies consequent at the same edge.
`define BOLE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bole: implication violated");

`endif

### rtl/bole_pkg.sv
package bole_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int REQ_W  = 4;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 6;
  localparam int STAT_W = 2;
  localparam int IDX_W  = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_BACK    = 4'd0,
    REQ_INS_FRONT   = 4'd1,
    REQ_DEL_BACK    = 4'd2,
    REQ_DEL_FRONT   = 4'd3,
    REQ_ERASE_VALUE = 4'd4,
    REQ_ERASE_AT    = 4'd5,
    REQ_FIND        = 4'd6,
    REQ_CLEAR       = 4'd7,
    REQ_READ_AT     = 4'd8
  } req_t;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  // What a cell loads at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LO,
    CELL_FROM_HI
  } cell_cmd_t;

endpackage

### rtl/bole_if.sv
interface bole_req_if;
  logic                        valid;
  logic                        ready;
  logic [bole_pkg::REQ_W-1:0]  req_type;
  logic [bole_pkg::VAL_W-1:0]  value;
  logic [bole_pkg::POS_W-1:0]  position;

  modport source (output valid, req_type, value, position, input ready);
  modport sink   (input valid, req_type, value, position, output ready);
endinterface

interface bole_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bole_pkg::STAT_W-1:0] status;
  logic [bole_pkg::IDX_W-1:0]  index;
  logic [bole_pkg::VAL_W-1:0]  read_value;
  logic [bole_pkg::IDX_W-1:0]  removed;
  logic [bole_pkg::IDX_W-1:0]  count;

  modport source (output valid, status, index, read_value, removed, count, input ready);
  modport sink   (input valid, status, index, read_value, removed, count, output ready);
endinterface

### rtl/bole_cell.sv
module bole_cell #(
  parameter int DATA_WIDTH = bole_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  bole_pkg::cell_cmd_t   cmd,
  input  logic [DATA_WIDTH-1:0] key,
  input  logic [DATA_WIDTH-1:0] lo_data,
  input  logic [DATA_WIDTH-1:0] hi_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  match
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    case (cmd)
      bole_pkg::CELL_LOAD:    data_nxt = key;
      bole_pkg::CELL_FROM_LO: data_nxt = lo_data;
      bole_pkg::CELL_FROM_HI: data_nxt = hi_data;
      default:                data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign match = (data_r == key);

endmodule

### rtl/bounded_ordered_list_engine_core.sv
// channel  | dir | handshake          | payload
// in_req   | in  | valid/ready        | req_type, value, position
// out_rsp  | out | valid/ready        | status, index, read_value, removed, count
//
// A beat is accepted, then executed in the cell row.
// erase_value removes one match per cycle while execute is not waiting on out_rsp.
// Reset (rst_n, sync) empties the list; entry storage is not cleared.
// The execute cycle waits while a finished result is still held on out_rsp;
// a new beat is taken as soon as the previous one has left execute.
`include "bounded_ordered_list_engine_core_defines.svh"

module bounded_ordered_list_engine_core #(
  parameter int CAPACITY   = bole_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = bole_pkg::DATA_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  bole_req_if.sink   in_req,
  bole_rsp_if.source out_rsp
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = CW + bole_pkg::POS_W;
  localparam int VW = bole_pkg::VAL_W;
  localparam int XW = bole_pkg::IDX_W;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                      state_r, state_nxt;
  logic [bole_pkg::REQ_W-1:0]  req_r, req_nxt;
  logic [DATA_WIDTH-1:0]       key_r, key_nxt;
  logic [bole_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               hits_r, hits_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [bole_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic [XW-1:0]               out_index_r, out_index_nxt;
  logic [VW-1:0]               out_rdata_r, out_rdata_nxt;
  logic [XW-1:0]               out_removed_r, out_removed_nxt;
  logic [XW-1:0]               out_count_r, out_count_nxt;

  bole_pkg::cell_cmd_t   cmd   [CAPACITY];
  logic [DATA_WIDTH-1:0] cdata [CAPACITY];
  logic [CAPACITY-1:0]   cmatch;
  logic [CAPACITY-1:0]   live_v, match_v, pre_v, first_v;
  logic [IW-1:0]         first_idx;
  logic                  any_hit;

  logic [DATA_WIDTH+VW-1:0] val_wide;
  logic [DATA_WIDTH+VW-1:0] rd_wide;
  logic [PW-1:0]            pos_ext, cnt_ext;
  logic                     pos_ok, full, empty, go, done;
  logic [CW-1:0]            res_idx;
  logic [bole_pkg::STAT_W-1:0] res_status;
  logic [VW-1:0]            res_rdata;
  logic [CW+XW-1:0]         idx_wide, cnt_wide, hit_wide;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] lo_d, hi_d;
      if (g == 0) begin : g_lo0
        assign lo_d = key_r;
      end else begin : g_lo
        assign lo_d = cdata[g-1];
      end
      if (g == CAPACITY - 1) begin : g_hiN
        assign hi_d = cdata[g];
      end else begin : g_hi
        assign hi_d = cdata[g+1];
      end
      bole_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
        .clk     (clk),
        .cmd     (cmd[g]),
        .key     (key_r),
        .lo_data (lo_d),
        .hi_data (hi_d),
        .data    (cdata[g]),
        .match   (cmatch[g])
      );
    end
  endgenerate

  assign pos_ext = {{CW{1'b0}}, pos_r};
  assign cnt_ext = {{bole_pkg::POS_W{1'b0}}, count_r};
  assign pos_ok  = pos_ext < cnt_ext;
  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);
  assign go      = (state_r == S_EXEC) && (!out_valid_r || out_rsp.ready);

  // First live match: log-depth prefix OR over the row.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      live_v[i] = PW'(i) < cnt_ext;
    end
    match_v = cmatch & live_v;
    pre_v   = match_v;
    for (int d = 1; d < CAPACITY; d = d * 2) begin
      pre_v = pre_v | (pre_v << d);
    end
    any_hit   = pre_v[CAPACITY-1];
    first_v   = match_v & ~(pre_v << 1);
    first_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_v[i]) first_idx = first_idx | IW'(i);
    end
  end

  assign val_wide = {{DATA_WIDTH{1'b0}}, in_req.value};
  assign rd_wide  = {{VW{1'b0}}, cdata[pos_ext[IW-1:0]]};

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) cmd[i] = bole_pkg::CELL_HOLD;
    count_nxt  = count_r;
    hits_nxt   = hits_r;
    done       = 1'b1;
    res_status = bole_pkg::ST_OK;
    res_idx    = '0;
    res_rdata  = '0;
    if (go) begin
      case (bole_pkg::req_t'(req_r))
        bole_pkg::REQ_INS_BACK: begin
          res_idx = count_r;
          if (full) begin
            res_status = bole_pkg::ST_FULL;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (CW'(i) == count_r) cmd[i] = bole_pkg::CELL_LOAD;
            end
            count_nxt = count_r + 1'b1;
          end
        end
        bole_pkg::REQ_INS_FRONT: begin
          if (full) begin
            res_status = bole_pkg::ST_FULL;
            res_idx    = count_r;
          end else begin
            for (int i = 1; i < CAPACITY; i++) cmd[i] = bole_pkg::CELL_FROM_LO;
            cmd[0]    = bole_pkg::CELL_LOAD;
            count_nxt = count_r + 1'b1;
          end
        end
        bole_pkg::REQ_DEL_BACK: begin
          if (empty) res_status = bole_pkg::ST_RANGE;
          else       count_nxt  = count_r - 1'b1;
        end
        bole_pkg::REQ_DEL_FRONT: begin
          if (empty) begin
            res_status = bole_pkg::ST_RANGE;
          end else begin
            for (int i = 0; i < CAPACITY; i++) cmd[i] = bole_pkg::CELL_FROM_HI;
            count_nxt = count_r - 1'b1;
          end
        end
        bole_pkg::REQ_ERASE_VALUE: begin
          // one match squeezed out per cycle while out_rsp does not hold execute, until none is left
          if (any_hit) begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (pre_v[i]) cmd[i] = bole_pkg::CELL_FROM_HI;
            end
            count_nxt = count_r - 1'b1;
            hits_nxt  = hits_r + 1'b1;
            done      = 1'b0;
          end
        end
        bole_pkg::REQ_ERASE_AT: begin
          if (!pos_ok) begin
            res_status = bole_pkg::ST_RANGE;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (PW'(i) >= pos_ext) cmd[i] = bole_pkg::CELL_FROM_HI;
            end
            count_nxt = count_r - 1'b1;
          end
        end
        bole_pkg::REQ_FIND: begin
          if (any_hit) begin
            res_idx = CW'(first_idx);
          end else begin
            res_status = bole_pkg::ST_NOT_FOUND;
            res_idx    = count_r;
          end
        end
        bole_pkg::REQ_CLEAR: count_nxt = '0;
        bole_pkg::REQ_READ_AT: begin
          if (pos_ok) res_rdata  = rd_wide[VW-1:0];
          else        res_status = bole_pkg::ST_RANGE;
        end
        default: ;
      endcase
    end
  end

  assign idx_wide = {{XW{1'b0}}, res_idx};
  assign cnt_wide = {{XW{1'b0}}, count_nxt};
  assign hit_wide = {{XW{1'b0}}, hits_r};

  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    key_nxt         = key_r;
    pos_nxt         = pos_r;
    out_valid_nxt   = out_valid_r && !out_rsp.ready;
    out_status_nxt  = out_status_r;
    out_index_nxt   = out_index_r;
    out_rdata_nxt   = out_rdata_r;
    out_removed_nxt = out_removed_r;
    out_count_nxt   = out_count_r;
    if (state_r == S_IDLE && in_req.valid) begin
      state_nxt = S_EXEC;
      req_nxt   = in_req.req_type;
      key_nxt   = val_wide[DATA_WIDTH-1:0];
      pos_nxt   = in_req.position;
    end
    if (go && done) begin
      state_nxt       = S_IDLE;
      out_valid_nxt   = 1'b1;
      out_status_nxt  = res_status;
      out_index_nxt   = idx_wide[XW-1:0];
      out_rdata_nxt   = res_rdata;
      out_removed_nxt = (bole_pkg::req_t'(req_r) == bole_pkg::REQ_ERASE_VALUE) ?
                        hit_wide[XW-1:0] : '0;
      out_count_nxt   = cnt_wide[XW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      hits_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      // tally is spent on the finishing edge, so idle always sees zero
      hits_r      <= (go && done) ? '0 : hits_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r         <= req_nxt;
    key_r         <= key_nxt;
    pos_r         <= pos_nxt;
    out_status_r  <= out_status_nxt;
    out_index_r   <= out_index_nxt;
    out_rdata_r   <= out_rdata_nxt;
    out_removed_r <= out_removed_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign in_req.ready       = (state_r == S_IDLE);
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.status     = out_status_r;
  assign out_rsp.index      = out_index_r;
  assign out_rsp.read_value = out_rdata_r;
  assign out_rsp.removed    = out_removed_r;
  assign out_rsp.count      = out_count_r;

  `BOLE_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CW'(CAPACITY))
  `BOLE_ASSERT_ALWAYS(a_hits_bound, clk, rst_n,
                      ({1'b0, hits_r} + {1'b0, count_r}) <= (CW + 1)'(CAPACITY))
  `BOLE_ASSERT_IMPL(a_idle_no_hits, clk, rst_n, state_r == S_IDLE, hits_r == '0)
  `BOLE_ASSERT_IMPL(a_count_out, clk, rst_n, $rose(out_valid_r),
                    out_count_r == cnt_ext[XW-1:0])

endmodule
